>>> design/tlb_page_table_fifo_pager_unit_assert.svh
// Assertion macros for the TLB pager unit.
// Used by tlb_page_table_fifo_pager_unit; expects signals clock and reset.
`ifndef TLB_PAGE_TABLE_FIFO_PAGER_UNIT_ASSERT_SVH
`define TLB_PAGE_TABLE_FIFO_PAGER_UNIT_ASSERT_SVH

// same-cycle implication
`define TLBPG_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tlbpg assertion failed");

// next-cycle implication
`define TLBPG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tlbpg assertion failed");

`endif

>>> design/tlbpg_pkg.sv
// Shared types and constants of the TLB pager unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tlbpg_pkg;

   localparam int PID_W    = 4;
   localparam int PAGE_W   = 6;
   localparam int OFF_W    = 12;
   localparam int CFG_W    = 4;
   localparam int FRAME_W  = 4;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 32;

   typedef enum logic [STATUS_W-1:0] {
      STAT_HIT      = 3'd0,
      STAT_HARD     = 3'd1,
      STAT_SOFT     = 3'd2,
      STAT_FREED    = 3'd3,
      STAT_BAD_PROC = 3'd4
   } status_type;

   typedef enum logic {
      ACT_ACCESS = 1'b0,
      ACT_FREE   = 1'b1
   } action_type;

endpackage
`default_nettype wire

>>> design/tlb_page_table_fifo_pager_unit.sv
// TLB hit or invalid process: the accepted word goes from S_DECODE straight to S_RESP. Miss:
// S_LOOK, a free-frame scan (S_FSCAN), S_PTW and a TLB slot scan (S_TFILL); a FIFO victim adds
// a page-table walk (S_VSWEEP) over all active process tables through the single page-table
// memory. Free: a sweep of the process table (S_FREE). One word in flight; the next word can be
// accepted in the cycle after the result loads, and the result stage holds while the previous
// result waits. Reset (synchronous, active high) clears control state, then sweeps all
// PROCESS_LIMIT*PAGES_PER_PROCESS table entries; raising active_processes sweeps the new tables.
`timescale 1ns / 1ps
`default_nettype none
`include "tlb_page_table_fifo_pager_unit_assert.svh"
module tlb_page_table_fifo_pager_unit #(
   parameter int FRAME_COUNT       = 16,
   parameter int PAGES_PER_PROCESS = 64,
   parameter int PROCESS_LIMIT     = 8,
   parameter int TLB_ENTRIES       = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_action,
   input  wire logic [tlbpg_pkg::PID_W-1:0]   req_process_id,
   input  wire logic [tlbpg_pkg::PAGE_W-1:0]  req_page_number,
   input  wire logic [tlbpg_pkg::OFF_W-1:0]   req_offset,
   input  wire logic                          req_access_mode,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [tlbpg_pkg::STATUS_W-1:0]     rsp_status,
   output logic [tlbpg_pkg::FRAME_W-1:0]      rsp_frame,
   output logic [tlbpg_pkg::OFF_W-1:0]        rsp_offset_out,
   output logic                               rsp_evicted,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [tlbpg_pkg::CFG_W-1:0]   csr_active_processes
);

   localparam int TABLE = PROCESS_LIMIT * PAGES_PER_PROCESS;
   localparam int AW    = (TABLE > 1) ? $clog2(TABLE) : 1;
   localparam int FW    = $clog2(FRAME_COUNT);
   localparam int TW    = $clog2(TLB_ENTRIES);
   localparam int AC    = $clog2(PROCESS_LIMIT + 1);
   localparam int PAGES_IN = 1 << tlbpg_pkg::PAGE_W;
   localparam logic [FW:0] NO_FRAME = '1;

   typedef struct packed {
      logic        valid;
      logic [FW:0] frame;
   } pte_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_LOOK, S_FSCAN, S_VSWEEP, S_PTW, S_TFILL, S_FREE, S_RESP
   } state_type;

   // page-table memory
   pte_type pt_mem [TABLE];
   pte_type rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   pte_type       wr_data;

   state_type state_ff;
   logic [AC-1:0] active_ff;
   logic [tlbpg_pkg::PID_W-1:0]  pid_ff;
   logic [tlbpg_pkg::PAGE_W-1:0] page_ff;
   logic [tlbpg_pkg::OFF_W-1:0]  off_ff;
   logic                         action_ff;
   logic [AW:0] sweep_ff, sweep_start_ff, sweep_end_ff;
   logic [FW-1:0] fidx_ff, victim_ff, take_ff;
   logic [FW-1:0] ring_ff [FRAME_COUNT];
   logic [FW-1:0] head_ff, tail_ff;
   logic [FRAME_COUNT-1:0] occ_ff;
   logic hard_ff, ev_ff, hit_ff;

   logic [TLB_ENTRIES-1:0] tlb_valid_ff;
   logic [tlbpg_pkg::PAGE_W-1:0] tlb_page_ff  [TLB_ENTRIES];
   logic [FW-1:0]                tlb_frame_ff [TLB_ENTRIES];
   logic [tlbpg_pkg::COUNT_W-1:0] tlb_cnt_ff  [TLB_ENTRIES];
   logic [TW-1:0] tidx_ff, tslot_ff;
   logic [tlbpg_pkg::COUNT_W-1:0] least_ff;

   tlbpg_pkg::status_type rsp_status_ff;
   logic [FW-1:0]                rsp_frame_ff;
   logic [tlbpg_pkg::OFF_W-1:0]  rsp_off_ff;
   logic rsp_ev_ff, rsp_valid_ff;

   logic [tlbpg_pkg::PAGE_W-1:0] page_mod_tab [PAGES_IN];
   for (genvar g = 0; g < PAGES_IN; g++) begin : g_mod
      assign page_mod_tab[g] = tlbpg_pkg::PAGE_W'(g % PAGES_PER_PROCESS);
   end

   logic [tlbpg_pkg::PAGE_W-1:0] page_m;
   logic [AW-1:0] base_addr, entry_addr;
   logic [AW:0]   active_limit;
   logic          pid_bad;
   logic          hit;
   logic [TW-1:0] hit_idx;
   logic          fill_done;
   logic [TW-1:0] fill_slot;
   logic [AC-1:0] cfg_n;
   logic          sweep_rd, sweep_wr, victim_match;

   always_comb begin
      page_m       = page_mod_tab[page_ff];
      base_addr    = AW'((int'(pid_ff) - 1) * PAGES_PER_PROCESS);
      entry_addr   = AW'(int'(base_addr) + int'(page_m));
      active_limit = (AW+1)'(int'(active_ff) * PAGES_PER_PROCESS);
      pid_bad      = (pid_ff == '0) || (8'(pid_ff) > 8'(active_ff));
      cfg_n = (8'(csr_active_processes) > 8'(PROCESS_LIMIT)) ? AC'(PROCESS_LIMIT)
                                                            : AC'(csr_active_processes);
   end

   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (tlb_valid_ff[i] && tlb_page_ff[i] == page_m) begin
            hit     = 1'b1;
            hit_idx = TW'(i);
         end
      end
   end

   always_comb begin
      fill_done = !tlb_valid_ff[tidx_ff] || (int'(tidx_ff) == TLB_ENTRIES - 1);
      if (!tlb_valid_ff[tidx_ff] || tlb_cnt_ff[tidx_ff] < least_ff) begin
         fill_slot = tidx_ff;
      end else begin
         fill_slot = tslot_ff;
      end
   end

   // victim and free sweeps read entry k and write back entry k-1, so the two ports never collide
   always_comb begin
      sweep_rd     = sweep_ff < sweep_end_ff;
      sweep_wr     = sweep_ff > sweep_start_ff;
      victim_match = rd_data_ff.frame == {1'b0, victim_ff};
      rd_addr      = sweep_ff[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = AW'(sweep_ff - 1'b1);
      wr_data      = '{valid: 1'b0, frame: NO_FRAME};
      unique case (state_ff)
         S_DECODE: rd_addr = entry_addr;
         S_VSWEEP: wr_en = sweep_wr && victim_match;
         S_FREE: begin
            wr_en   = sweep_wr && rd_data_ff.valid;
            wr_data = '{valid: 1'b0, frame: rd_data_ff.frame};
         end
         S_CLEAR: begin
            wr_en   = sweep_rd;
            wr_addr = sweep_ff[AW-1:0];
         end
         S_PTW: begin
            wr_en   = 1'b1;
            wr_addr = entry_addr;
            wr_data = '{valid: 1'b1, frame: {1'b0, take_ff}};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pt_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= pt_mem[rd_addr];
   end

   assign req_ready      = (state_ff == S_IDLE) && !csr_valid;
   assign csr_ready      = state_ff == S_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_frame      = tlbpg_pkg::FRAME_W'(rsp_frame_ff);
   assign rsp_offset_out = rsp_off_ff;
   assign rsp_evicted    = rsp_ev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         sweep_ff       <= '0;
         sweep_start_ff <= '0;
         sweep_end_ff   <= (AW+1)'(TABLE);
         active_ff      <= '0;
         occ_ff         <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         tlb_valid_ff   <= '0;
         for (int i = 0; i < TLB_ENTRIES; i++) begin
            tlb_cnt_ff[i] <= '0;
         end
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != S_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (!sweep_rd) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (csr_valid) begin
                  active_ff <= cfg_n;
                  if (cfg_n > active_ff) begin
                     sweep_ff     <= active_limit;
                     sweep_end_ff <= (AW+1)'(int'(cfg_n) * PAGES_PER_PROCESS);
                     state_ff     <= S_CLEAR;
                  end
               end else if (req_valid) begin
                  pid_ff    <= req_process_id;
                  page_ff   <= req_page_number;
                  off_ff    <= req_offset;
                  action_ff <= req_action;
                  state_ff  <= S_DECODE;
               end
            end
            S_DECODE: begin
               ev_ff  <= 1'b0;
               hit_ff <= !pid_bad && (action_ff == tlbpg_pkg::ACT_ACCESS) && hit;
               if (pid_bad) begin
                  hard_ff  <= 1'b0;
                  state_ff <= S_RESP;
               end else if (action_ff == tlbpg_pkg::ACT_FREE) begin
                  sweep_ff       <= (AW+1)'(base_addr);
                  sweep_start_ff <= (AW+1)'(base_addr);
                  sweep_end_ff   <= (AW+1)'(int'(base_addr) + PAGES_PER_PROCESS);
                  state_ff       <= S_FREE;
               end else if (hit) begin
                  if (tlb_cnt_ff[hit_idx] != '1) begin
                     tlb_cnt_ff[hit_idx] <= tlb_cnt_ff[hit_idx] + 1'b1;
                  end
                  take_ff  <= tlb_frame_ff[hit_idx];
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_LOOK;
               end
            end
            S_LOOK: begin
               hard_ff  <= !rd_data_ff.valid;
               fidx_ff  <= '0;
               state_ff <= S_FSCAN;
            end
            S_FSCAN: begin
               if (!occ_ff[fidx_ff]) begin
                  occ_ff[fidx_ff]  <= 1'b1;
                  ring_ff[tail_ff] <= fidx_ff;
                  tail_ff  <= (int'(tail_ff) == FRAME_COUNT - 1) ? '0 : tail_ff + 1'b1;
                  take_ff  <= fidx_ff;
                  state_ff <= S_PTW;
               end else if (int'(fidx_ff) == FRAME_COUNT - 1) begin
                  victim_ff      <= ring_ff[head_ff];
                  head_ff  <= (int'(head_ff) == FRAME_COUNT - 1) ? '0 : head_ff + 1'b1;
                  sweep_ff       <= '0;
                  sweep_start_ff <= '0;
                  sweep_end_ff   <= active_limit;
                  state_ff       <= S_VSWEEP;
               end else begin
                  fidx_ff <= fidx_ff + 1'b1;
               end
            end
            S_VSWEEP: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (!sweep_rd) begin
                  ring_ff[tail_ff] <= victim_ff;
                  tail_ff  <= (int'(tail_ff) == FRAME_COUNT - 1) ? '0 : tail_ff + 1'b1;
                  take_ff  <= victim_ff;
                  ev_ff    <= 1'b1;
                  state_ff <= S_PTW;
               end
            end
            S_PTW: begin
               occ_ff[take_ff] <= 1'b1;
               tslot_ff <= '0;
               least_ff <= tlb_cnt_ff[0];
               tidx_ff  <= TW'(1);
               state_ff <= S_TFILL;
            end
            S_TFILL: begin
               if (fill_done) begin
                  tlb_valid_ff[fill_slot] <= 1'b1;
                  tlb_page_ff[fill_slot]  <= page_m;
                  tlb_frame_ff[fill_slot] <= take_ff;
                  tlb_cnt_ff[fill_slot]   <= tlbpg_pkg::COUNT_W'(1);
                  state_ff <= S_RESP;
               end else begin
                  tslot_ff <= fill_slot;
                  least_ff <= tlb_cnt_ff[fill_slot];
                  tidx_ff  <= tidx_ff + 1'b1;
               end
            end
            S_FREE: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_wr && rd_data_ff.valid
                   && rd_data_ff.frame < (FW+1)'(FRAME_COUNT)) begin
                  occ_ff[rd_data_ff.frame[FW-1:0]] <= 1'b0;
               end
               if (!sweep_rd) begin
                  state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_off_ff   <= off_ff;
                  rsp_ev_ff    <= ev_ff;
                  if (pid_bad) begin
                     rsp_status_ff <= tlbpg_pkg::STAT_BAD_PROC;
                     rsp_frame_ff  <= '0;
                  end else if (action_ff == tlbpg_pkg::ACT_FREE) begin
                     rsp_status_ff <= tlbpg_pkg::STAT_FREED;
                     rsp_frame_ff  <= '0;
                  end else if (hit_ff) begin
                     rsp_status_ff <= tlbpg_pkg::STAT_HIT;
                     rsp_frame_ff  <= take_ff;
                  end else begin
                     rsp_status_ff <= hard_ff ? tlbpg_pkg::STAT_HARD : tlbpg_pkg::STAT_SOFT;
                     rsp_frame_ff  <= take_ff;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `TLBPG_ASSERT_NOW(a_ports_apart, wr_en && (state_ff == S_FREE || state_ff == S_VSWEEP),
      wr_addr != rd_addr)
   `TLBPG_ASSERT_NOW(a_hit_no_evict,
      rsp_valid_ff && rsp_status_ff == tlbpg_pkg::STAT_HIT, !rsp_ev_ff)
   `TLBPG_ASSERT_NEXT(a_clear_blocks, state_ff == S_CLEAR, !req_ready || !sweep_rd)

endmodule
`default_nettype wire

>>> tb/tlb_page_table_fifo_pager_unit_tb.sv
// Self-checking testbench for tlb_page_table_fifo_pager_unit: TLB lookups, demand paging,
// FIFO frame eviction, process frees and process count settings against a built-in predictor.
// Depends on tlbpg_pkg and the unit RTL only.
`timescale 1ns / 1ps
module tlb_page_table_fifo_pager_unit_tb;

   localparam int FRAMES = 16;
   localparam int PAGES  = 64;
   localparam int PROCS  = 8;
   localparam int SLOTS  = 8;
   localparam int NO_FRAME = 'hFFFF;
   localparam int SETTLE = 700;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      tlbpg_pkg::status_type         status;
      logic [tlbpg_pkg::FRAME_W-1:0] frame;
      logic [tlbpg_pkg::OFF_W-1:0]   offset_out;
      logic                          evicted;
   } pager_word_type;

   logic clock = 0;
   logic reset;
   logic req_valid, req_ready, req_action, req_access_mode;
   logic [tlbpg_pkg::PID_W-1:0]  req_process_id;
   logic [tlbpg_pkg::PAGE_W-1:0] req_page_number;
   logic [tlbpg_pkg::OFF_W-1:0]  req_offset;
   logic rsp_valid, rsp_evicted;
   logic rsp_ready = 1'b0;
   logic [tlbpg_pkg::STATUS_W-1:0] rsp_status;
   logic [tlbpg_pkg::FRAME_W-1:0]  rsp_frame;
   logic [tlbpg_pkg::OFF_W-1:0]    rsp_offset_out;
   logic csr_valid, csr_ready;
   logic [tlbpg_pkg::CFG_W-1:0] csr_active_processes;

   pager_word_type pending_words[$];
   int fail_count = 0;
   bit quiet = 0;
   int stall_left = 0;
   int hold_asked = 0;
   int hold_seen = 0;

   // predictor state
   int          live_procs;
   bit          tlb_live[SLOTS];
   int          tlb_pg[SLOTS];
   int          tlb_fr[SLOTS];
   int unsigned tlb_uses[SLOTS];
   bit          frame_busy[FRAMES];
   bit          pte_valid[PROCS*PAGES];
   int          pte_frame[PROCS*PAGES];
   int          fifo_ring[FRAMES];
   int          fifo_head, fifo_tail;

   tlb_page_table_fifo_pager_unit uut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

   function automatic void clear_process(int p);
      for (int j = 0; j < PAGES; j++) begin
         pte_valid[p*PAGES+j] = 1'b0;
         pte_frame[p*PAGES+j] = NO_FRAME;
      end
   endfunction

   function automatic void pager_reset();
      live_procs = 0;
      fifo_head = 0;
      fifo_tail = 0;
      for (int i = 0; i < SLOTS; i++) begin
         tlb_live[i] = 1'b0; tlb_pg[i] = 0; tlb_fr[i] = 0; tlb_uses[i] = 0;
      end
      for (int i = 0; i < FRAMES; i++) begin
         frame_busy[i] = 1'b0; fifo_ring[i] = 0;
      end
      for (int p = 0; p < PROCS; p++) clear_process(p);
   endfunction

   function automatic void pager_set_procs(int value);
      int n;
      n = (value > PROCS) ? PROCS : value;
      for (int p = live_procs; p < n; p++) clear_process(p);
      live_procs = n;
   endfunction

   function automatic pager_word_type pager_predict(tlbpg_pkg::action_type act, int pid,
                                                    int page, int off);
      pager_word_type w;
      int base, f, slot;
      int unsigned least;
      bit hard;
      w.status = tlbpg_pkg::STAT_HIT;
      w.frame = '0;
      w.offset_out = tlbpg_pkg::OFF_W'(off);
      w.evicted = 1'b0;
      if (pid == 0 || pid > live_procs) begin
         w.status = tlbpg_pkg::STAT_BAD_PROC;
         return w;
      end
      base = (pid - 1) * PAGES;
      if (act == tlbpg_pkg::ACT_FREE) begin
         for (int i = 0; i < PAGES; i++)
            if (pte_valid[base+i]) begin
               if (pte_frame[base+i] < FRAMES) frame_busy[pte_frame[base+i]] = 1'b0;
               pte_valid[base+i] = 1'b0;
            end
         w.status = tlbpg_pkg::STAT_FREED;
         return w;
      end
      for (int i = 0; i < SLOTS; i++)
         if (tlb_live[i] && tlb_pg[i] == page) begin
            if (tlb_uses[i] != 32'hFFFF_FFFF) tlb_uses[i]++;
            w.frame = tlbpg_pkg::FRAME_W'(tlb_fr[i]);
            return w;
         end
      hard = !pte_valid[base+page];
      f = -1;
      for (int i = 0; i < FRAMES; i++)
         if (f < 0 && !frame_busy[i]) f = i;
      if (f < 0) begin
         f = fifo_ring[fifo_head] % FRAMES;
         fifo_head = (fifo_head + 1) % FRAMES;
         for (int i = 0; i < live_procs * PAGES; i++)
            if (pte_frame[i] == f) begin
               pte_valid[i] = 1'b0;
               pte_frame[i] = NO_FRAME;
            end
         w.evicted = 1'b1;
      end
      fifo_ring[fifo_tail] = f;
      fifo_tail = (fifo_tail + 1) % FRAMES;
      frame_busy[f] = 1'b1;
      pte_frame[base+page] = f;
      pte_valid[base+page] = 1'b1;
      slot = 0;
      least = tlb_uses[0];
      for (int i = 1; i < SLOTS; i++) begin
         if (!tlb_live[i]) begin
            slot = i;
            break;
         end
         if (tlb_uses[i] < least) begin
            least = tlb_uses[i];
            slot = i;
         end
      end
      tlb_live[slot] = 1'b1;
      tlb_pg[slot] = page;
      tlb_fr[slot] = f;
      tlb_uses[slot] = 1;
      w.status = hard ? tlbpg_pkg::STAT_HARD : tlbpg_pkg::STAT_SOFT;
      w.frame = tlbpg_pkg::FRAME_W'(f);
      return w;
   endfunction

   // receiver: random stalls, long hold-off on request
   always @(posedge clock) begin
      if (hold_seen != hold_asked) begin
         hold_seen <= hold_asked;
         stall_left <= HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet || ($urandom_range(0, 99) >= 15);
      end
   end

   always @(posedge clock) begin
      pager_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            $error("unexpected result word status=%0d", rsp_status);
            fail_count++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_frame !== want.frame) begin
               $error("frame expected %0d actual %0d", want.frame, rsp_frame);
               fail_count++;
            end
            if (rsp_offset_out !== want.offset_out) begin
               $error("offset_out expected %0d actual %0d", want.offset_out, rsp_offset_out);
               fail_count++;
            end
            if (rsp_evicted !== want.evicted) begin
               $error("evicted expected %0d actual %0d", want.evicted, rsp_evicted);
               fail_count++;
            end
         end
      end
   end

   task automatic send_word(tlbpg_pkg::action_type act, int pid, int page, int off, bit mode);
      if (!quiet && $urandom_range(0, 99) < 15) repeat ($urandom_range(1, 6)) @(posedge clock);
      @(posedge clock);
      req_valid <= 1'b1;
      req_action <= act;
      req_process_id <= tlbpg_pkg::PID_W'(pid);
      req_page_number <= tlbpg_pkg::PAGE_W'(page);
      req_offset <= tlbpg_pkg::OFF_W'(off);
      req_access_mode <= mode;
      do @(posedge clock); while (!req_ready);
      pending_words.push_back(pager_predict(act, pid, page, off));
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   task automatic write_procs(int value);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_active_processes <= tlbpg_pkg::CFG_W'(value);
      do @(posedge clock); while (!csr_ready);
      pager_set_procs(value);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random();
      int pid, page;
      tlbpg_pkg::action_type act;
      act = ($urandom_range(0, 99) < 4) ? tlbpg_pkg::ACT_FREE : tlbpg_pkg::ACT_ACCESS;
      if ($urandom_range(0, 99) < 6) pid = $urandom_range(0, 15);
      else pid = $urandom_range(1, (live_procs > 0) ? live_procs : 1);
      page = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 19) : $urandom_range(0, 63);
      send_word(act, pid, page, $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
   endtask

   task automatic test_no_processes();
      send_word(tlbpg_pkg::ACT_ACCESS, 1, 0, 0, 1'b0);
      send_word(tlbpg_pkg::ACT_FREE, 1, 0, 4095, 1'b1);
      send_word(tlbpg_pkg::ACT_ACCESS, 0, 63, 123, 1'b0);
   endtask

   task automatic test_directed();
      write_procs(2);
      send_word(tlbpg_pkg::ACT_ACCESS, 1, 0, 0, 1'b0);
      send_word(tlbpg_pkg::ACT_ACCESS, 1, 0, 4095, 1'b1);
      send_word(tlbpg_pkg::ACT_ACCESS, 2, 0, 17, 1'b0);
      send_word(tlbpg_pkg::ACT_ACCESS, 2, 63, 4095, 1'b1);
      send_word(tlbpg_pkg::ACT_ACCESS, 0, 5, 1, 1'b0);
      send_word(tlbpg_pkg::ACT_ACCESS, 3, 5, 2, 1'b1);
      send_word(tlbpg_pkg::ACT_ACCESS, 15, 5, 3, 1'b0);
      send_word(tlbpg_pkg::ACT_FREE, 15, 5, 4, 1'b0);
      for (int i = 1; i <= 18; i++)
         send_word(tlbpg_pkg::ACT_ACCESS, 1 + (i % 2), i, i * 200, 1'(i % 2));
      send_word(tlbpg_pkg::ACT_FREE, 1, 0, 2048, 1'b0);
      send_word(tlbpg_pkg::ACT_ACCESS, 1, 2, 2049, 1'b1);
   endtask

   task automatic test_random(int procs, int count, bit calm_start);
      write_procs(procs);
      for (int i = 0; i < count; i++) begin
         quiet = calm_start && i < count / 2;
         send_random();
      end
      quiet = 0;
   endtask

   task automatic test_backpressure();
      wait_drained();
      @(posedge clock);
      hold_asked++;
      for (int i = 0; i < 12; i++) send_random();
   endtask

   task automatic test_drain_pause();
      for (int i = 0; i < 30; i++) send_random();
      wait_drained();
      for (int i = 0; i < 30; i++) send_random();
   endtask

   initial begin
      reset = 1;
      req_valid = 0; req_action = 0; req_process_id = 0; req_page_number = 0;
      req_offset = 0; req_access_mode = 0;
      csr_valid = 0; csr_active_processes = 0;
      pager_reset();
      repeat (8) @(posedge clock);
      reset <= 0;
      test_no_processes();
      test_directed();
      test_random(15, 300, 1);
      test_backpressure();
      test_random(1, 250, 0);
      test_random(3, 300, 0);
      test_drain_pause();
      test_random(0, 20, 0);
      test_random(5, 250, 0);
      test_random(8, 300, 0);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0 && pending_words.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
